### sv/pvfs_pkg.sv
package pvfs_pkg;

	localparam int FRAME_LEN = 512;
	localparam int NBINS = FRAME_LEN + 1;
	localparam int BIN_W = $clog2(NBINS);
	localparam int MAG_W = 25;
	localparam int PH_W = 16;
	localparam int STEP_W = 18;
	localparam int IN_W = 24;
	localparam int OUT_W = 25;
	localparam int IDX_W = 6;
	localparam int MAX_RES = 64;
	localparam int CNT_W = 7;
	localparam int POS_W = 19;
	localparam int CORDIC_STEPS = 24;
	localparam int K_W = 5;
	localparam int CW = 36;
	localparam int MEM_W = MAG_W + 2 * PH_W;
	localparam logic [STEP_W-1:0] STEP_RESET = 18'd32768;
	localparam logic [31:0] INV_GAIN = 32'd2608131496;
	localparam logic signed [27:0] OUT_MAX = 28'sd11863283;
	localparam logic signed [27:0] OUT_MIN = -28'sd11863284;

	typedef logic [31:0] angle_tab_t [CORDIC_STEPS];

	function automatic longint const_quot(input longint num, input longint den);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r << 1) | ((num >> b) & longint'(1));
			if (r >= den) begin
				r = r - den;
				q = q | (longint'(1) << b);
			end
		end
		return q;
	endfunction

	function automatic angle_tab_t build_angles();
		angle_tab_t tab;
		longint acc;
		longint term;
		longint e;
		tab[0] = 32'h2000_0000;
		for (int k = 1; k < CORDIC_STEPS; k++) begin
			acc = 0;
			for (int n = 0; n < 16; n++) begin
				e = longint'(k) * (2 * n + 1);
				if (e <= 30) begin
					term = const_quot(longint'(1) << (30 - e), longint'(2 * n + 1));
					acc = ((n & 1) != 0) ? acc - term : acc + term;
				end
			end
			tab[k] = 32'((acc * 64'sd683565276 + (longint'(1) << 29)) >>> 30);
		end
		return tab;
	endfunction

	localparam angle_tab_t ANGLES = build_angles();

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_SQRT,
		ST_POLAR,
		ST_ADV,
		ST_INTERP,
		ST_GAIN,
		ST_ROT,
		ST_WRITE
	} state_t;

	typedef enum logic {
		CM_VECTOR,
		CM_ROTATE
	} cordic_mode_t;

	typedef struct packed {
		logic start;
		cordic_mode_t mode;
	} cordic_ctl_t;

endpackage

### sv/pvfs_cordic.sv
module pvfs_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pvfs_pkg::cordic_ctl_t               ctl,
	input  logic signed [pvfs_pkg::CW-1:0]      x0,
	input  logic signed [pvfs_pkg::CW-1:0]      y0,
	input  logic [31:0]                         z0,
	output logic signed [pvfs_pkg::CW-1:0]      x,
	output logic signed [pvfs_pkg::CW-1:0]      y,
	output logic [31:0]                         z,
	output logic                                busy
);

	logic signed [pvfs_pkg::CW-1:0] x_q, y_q, sx, sy;
	logic [31:0] z_q, ang;
	logic [pvfs_pkg::K_W-1:0] k_q;
	logic busy_q;
	pvfs_pkg::cordic_mode_t mode_q;
	logic fwd;

	always_comb begin
		sx = x_q >>> k_q;
		sy = y_q >>> k_q;
		ang = pvfs_pkg::ANGLES[k_q];
		if (mode_q == pvfs_pkg::CM_VECTOR) begin
			fwd = !y_q[pvfs_pkg::CW-1];
		end else begin
			fwd = z_q[31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			k_q <= '0;
		end else if (busy_q) begin
			if (k_q == pvfs_pkg::K_W'(pvfs_pkg::CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
			k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
			mode_q <= ctl.mode;
		end else if (busy_q) begin
			if (fwd) begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - ang;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;
	assign busy = busy_q;

endmodule

### sv/phase_vocoder_frame_stretch_unit.sv
// Phase-vocoder time stretch, one spectrum bin per input request.
// Input channel (in_valid/in_stall): bin_real, bin_imag, last_bin. One bin is
// taken at a time; in_stall stays high from acceptance until the bin's state
// is written back.
// Output channel (out_valid/out_stall): one request per interpolated frame,
// frame_index counting from 0, run_end on the bin's last one, frame_end copied
// from last_bin. The output register holds a result while out_stall is high
// and the sequencer waits before loading the next one.
// Config channel (cfg_valid/cfg_ready/cfg_data): stretch_step, always ready.
// Sequence: the polar conversion runs a 24-step square root beside a 24-step
// vectoring CORDIC, then comes the phase advance, then per result the
// interpolation, gain multiply and rotation CORDIC while the receiver keeps
// up, and a last interpolation check and the write-back close the bin. In the
// first frame after reset a bin goes from polar conversion straight to the
// write-back and gives no results.
// Reset: step returns to 32768, frame position and bin counter to zero, and
// the block waits for a new first frame. Bin memories are not cleared.
module phase_vocoder_frame_stretch_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pvfs_pkg::IN_W-1:0]      bin_real,
	input  logic signed [pvfs_pkg::IN_W-1:0]      bin_imag,
	input  logic                                  last_bin,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pvfs_pkg::IDX_W-1:0]            frame_index,
	output logic signed [pvfs_pkg::OUT_W-1:0]     out_real,
	output logic signed [pvfs_pkg::OUT_W-1:0]     out_imag,
	output logic                                  run_end,
	output logic                                  frame_end,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pvfs_pkg::STEP_W-1:0]           cfg_data
);

	pvfs_pkg::state_t state_q, state_d;
	pvfs_pkg::cordic_ctl_t cctl;

	logic [pvfs_pkg::STEP_W-1:0] step_q;
	logic [pvfs_pkg::PH_W-1:0] fpos_q;
	logic [pvfs_pkg::BIN_W-1:0] bin_q;
	logic primed_q;

	logic signed [pvfs_pkg::IN_W-1:0] re_q, im_q;
	logic last_q;
	logic [47:0] sq_q;
	logic [26:0] rem_q;
	logic [23:0] root_q;
	logic [pvfs_pkg::K_W-1:0] sk_q;
	logic [pvfs_pkg::MAG_W-1:0] nmag_q;
	logic [pvfs_pkg::PH_W-1:0] nph_q, adv_q, run_q;
	logic [pvfs_pkg::POS_W-1:0] pos_q;
	logic [pvfs_pkg::CNT_W-1:0] cnt_q;
	logic [pvfs_pkg::MAG_W-1:0] m_q;

	logic [pvfs_pkg::MEM_W-1:0] mem_q [pvfs_pkg::NBINS];
	logic [pvfs_pkg::MEM_W-1:0] rd_q, wdata;
	logic [pvfs_pkg::MAG_W-1:0] prev_mag;
	logic [pvfs_pkg::PH_W-1:0] prev_ph, prev_run;

	logic signed [pvfs_pkg::CW-1:0] cx0, cy0, cx, cy;
	logic [31:0] cz0, cz;
	logic cbusy;

	logic in_acc, out_free, out_load, we, sq_done, loop_go;
	logic [26:0] rem_cat, trial;
	logic [pvfs_pkg::PH_W-1:0] half, dph;
	logic signed [34:0] tprod;
	logic [34:0] tround;
	logic signed [25:0] mdiff;
	logic signed [43:0] mprod;
	logic [43:0] msum;
	logic [56:0] gprod;
	logic signed [pvfs_pkg::CW-1:0] gx, vx, vy;
	logic rquad;
	logic [31:0] pz;
	logic signed [pvfs_pkg::CW-1:0] rxr, ryr;
	logic signed [27:0] vr, vi;
	logic [pvfs_pkg::POS_W-1:0] nxt_pos;

	assign {prev_mag, prev_ph, prev_run} = rd_q;
	assign half = bin_q[0] ? 16'h8000 : 16'h0000;
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign out_load = (state_q == pvfs_pkg::ST_ROT) && !cbusy && out_free;
	assign cfg_ready = 1'b1;
	assign sq_done = (sk_q == pvfs_pkg::K_W'(pvfs_pkg::CORDIC_STEPS - 1));
	assign loop_go = (pos_q[pvfs_pkg::POS_W-1:pvfs_pkg::PH_W] == '0) && !cnt_q[pvfs_pkg::CNT_W-1];

	always_comb begin
		rem_cat = {rem_q[24:0], sq_q[47:46]};
		trial = {1'b0, root_q, 2'b01};
		dph = nph_q - prev_ph - half;
		tprod = $signed(dph) * $signed({1'b0, step_q});
		tround = 35'(tprod + 35'sd32768);
		mdiff = $signed({1'b0, nmag_q}) - $signed({1'b0, prev_mag});
		mprod = mdiff * $signed({1'b0, pos_q[pvfs_pkg::PH_W-1:0]});
		msum = 44'(mprod + $signed({3'b0, prev_mag, 16'h0000}) + 44'sd32768);
		gprod = m_q * pvfs_pkg::INV_GAIN;
		gx = $signed({3'b0, gprod[56:24]});
		rquad = run_q[15] ^ run_q[14];
		pz = {run_q, 16'h0000};
		vx = $signed({{(pvfs_pkg::CW-pvfs_pkg::IN_W-8){bin_real[pvfs_pkg::IN_W-1]}}, bin_real, 8'h00});
		vy = $signed({{(pvfs_pkg::CW-pvfs_pkg::IN_W-8){bin_imag[pvfs_pkg::IN_W-1]}}, bin_imag, 8'h00});
		rxr = cx + 36'sd128;
		ryr = cy + 36'sd128;
		vr = rxr[35:8];
		vi = ryr[35:8];
		nxt_pos = pos_q + pvfs_pkg::POS_W'(step_q);
		wdata = {nmag_q, nph_q, primed_q ? run_q : nph_q};
	end

	always_comb begin
		cx0 = gx;
		cy0 = '0;
		cz0 = pz;
		if (state_q == pvfs_pkg::ST_IDLE) begin
			cx0 = bin_real[pvfs_pkg::IN_W-1] ? -vx : vx;
			cy0 = bin_real[pvfs_pkg::IN_W-1] ? -vy : vy;
			cz0 = bin_real[pvfs_pkg::IN_W-1] ? 32'h8000_0000 : 32'h0000_0000;
		end else if (rquad) begin
			cx0 = -gx;
			cz0 = pz ^ 32'h8000_0000;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pvfs_pkg::ST_IDLE:   if (in_acc) state_d = pvfs_pkg::ST_SQ_RE;
			pvfs_pkg::ST_SQ_RE:  state_d = pvfs_pkg::ST_SQ_IM;
			pvfs_pkg::ST_SQ_IM:  state_d = pvfs_pkg::ST_SQRT;
			pvfs_pkg::ST_SQRT:   if (sq_done) state_d = pvfs_pkg::ST_POLAR;
			pvfs_pkg::ST_POLAR: begin
				if (!cbusy) state_d = primed_q ? pvfs_pkg::ST_ADV : pvfs_pkg::ST_WRITE;
			end
			pvfs_pkg::ST_ADV:    state_d = pvfs_pkg::ST_INTERP;
			pvfs_pkg::ST_INTERP: state_d = loop_go ? pvfs_pkg::ST_GAIN : pvfs_pkg::ST_WRITE;
			pvfs_pkg::ST_GAIN:   state_d = pvfs_pkg::ST_ROT;
			pvfs_pkg::ST_ROT:    if (!cbusy && out_free) state_d = pvfs_pkg::ST_INTERP;
			pvfs_pkg::ST_WRITE:  state_d = pvfs_pkg::ST_IDLE;
			default:             state_d = pvfs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != pvfs_pkg::ST_IDLE);
		cctl.start = 1'b0;
		cctl.mode = pvfs_pkg::CM_VECTOR;
		we = (state_q == pvfs_pkg::ST_WRITE);
		if (state_q == pvfs_pkg::ST_IDLE) begin
			cctl.start = in_acc;
		end else if (state_q == pvfs_pkg::ST_GAIN) begin
			cctl.start = 1'b1;
			cctl.mode = pvfs_pkg::CM_ROTATE;
		end
	end

	pvfs_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.x0     (cx0),
		.y0     (cy0),
		.z0     (cz0),
		.x      (cx),
		.y      (cy),
		.z      (cz),
		.busy   (cbusy)
	);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[bin_q] <= wdata;
		end
		rd_q <= mem_q[bin_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pvfs_pkg::ST_IDLE;
			step_q <= pvfs_pkg::STEP_RESET;
			fpos_q <= '0;
			bin_q <= '0;
			primed_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				step_q <= cfg_data;
			end
			out_valid <= out_load || (out_valid && out_stall);
			if (state_q == pvfs_pkg::ST_INTERP && !loop_go && last_q) begin
				fpos_q <= pos_q[pvfs_pkg::PH_W-1:0];
			end
			if (we) begin
				if (last_q) begin
					bin_q <= '0;
					primed_q <= 1'b1;
				end else if (bin_q < pvfs_pkg::BIN_W'(pvfs_pkg::FRAME_LEN)) begin
					bin_q <= bin_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pvfs_pkg::ST_IDLE: begin
				if (in_acc) begin
					re_q <= bin_real;
					im_q <= bin_imag;
					last_q <= last_bin;
				end
			end
			pvfs_pkg::ST_SQ_RE: begin
				sq_q <= 48'(re_q * re_q);
			end
			pvfs_pkg::ST_SQ_IM: begin
				sq_q <= sq_q + 48'(im_q * im_q);
				rem_q <= '0;
				root_q <= '0;
				sk_q <= '0;
			end
			pvfs_pkg::ST_SQRT: begin
				sq_q <= {sq_q[45:0], 2'b00};
				sk_q <= sk_q + 1'b1;
				if (rem_cat >= trial) begin
					rem_q <= rem_cat - trial;
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q <= rem_cat;
					root_q <= {root_q[22:0], 1'b0};
				end
			end
			pvfs_pkg::ST_POLAR: begin
				nmag_q <= pvfs_pkg::MAG_W'(root_q) + pvfs_pkg::MAG_W'(rem_q > 27'(root_q));
				if (re_q == '0 && im_q == '0) begin
					nph_q <= '0;
				end else begin
					nph_q <= 16'((cz + 32'h0000_8000) >> 16);
				end
			end
			pvfs_pkg::ST_ADV: begin
				adv_q <= tround[31:16];
				run_q <= prev_run;
				pos_q <= pvfs_pkg::POS_W'(fpos_q);
				cnt_q <= '0;
			end
			pvfs_pkg::ST_INTERP: begin
				m_q <= msum[40:16];
			end
			pvfs_pkg::ST_ROT: begin
				if (!cbusy && out_free) begin
					frame_index <= cnt_q[pvfs_pkg::IDX_W-1:0];
					out_real <= (vr > pvfs_pkg::OUT_MAX) ? pvfs_pkg::OUT_W'(pvfs_pkg::OUT_MAX) :
						(vr < pvfs_pkg::OUT_MIN) ? pvfs_pkg::OUT_W'(pvfs_pkg::OUT_MIN) :
						vr[pvfs_pkg::OUT_W-1:0];
					out_imag <= (vi > pvfs_pkg::OUT_MAX) ? pvfs_pkg::OUT_W'(pvfs_pkg::OUT_MAX) :
						(vi < pvfs_pkg::OUT_MIN) ? pvfs_pkg::OUT_W'(pvfs_pkg::OUT_MIN) :
						vi[pvfs_pkg::OUT_W-1:0];
					run_end <= (nxt_pos[pvfs_pkg::POS_W-1:pvfs_pkg::PH_W] != '0) ||
						(cnt_q == pvfs_pkg::CNT_W'(pvfs_pkg::MAX_RES - 1));
					frame_end <= last_q;
					run_q <= run_q + half + adv_q;
					pos_q <= nxt_pos;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### sv/pvfs_checker.sv
module pvfs_assertions (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic signed [pvfs_pkg::IN_W-1:0]      bin_real,
	input logic signed [pvfs_pkg::IN_W-1:0]      bin_imag,
	input logic                                  last_bin,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [pvfs_pkg::IDX_W-1:0]            frame_index,
	input logic signed [pvfs_pkg::OUT_W-1:0]     out_real,
	input logic signed [pvfs_pkg::OUT_W-1:0]     out_imag,
	input logic                                  run_end,
	input logic                                  frame_end,
	input logic                                  cfg_valid,
	input logic                                  cfg_ready,
	input logic [pvfs_pkg::STEP_W-1:0]           cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_index) && $stable(out_real)
			&& $stable(out_imag) && $stable(run_end) && $stable(frame_end))
		else $error("stalled result changed");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a bin is in work");

	a_run_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_index == 6'd63 |-> run_end)
		else $error("run longer than the result cap");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind phase_vocoder_frame_stretch_unit pvfs_assertions u_pvfs_checker (.*);

### tb/sv/pvfs_checker.sv
module pvfs_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [pvfs_pkg::IN_W-1:0]  bin_real,
	input  logic signed [pvfs_pkg::IN_W-1:0]  bin_imag,
	input  logic                              last_bin,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [pvfs_pkg::IDX_W-1:0]        frame_index,
	input  logic signed [pvfs_pkg::OUT_W-1:0] out_real,
	input  logic signed [pvfs_pkg::OUT_W-1:0] out_imag,
	input  logic                              run_end,
	input  logic                              frame_end,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [pvfs_pkg::STEP_W-1:0]       cfg_data,
	output int                                errors,
	output int                                pending,
	output int                                checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import pvfs_pkg::*;

	typedef struct {
		logic [IDX_W-1:0]        idx;
		logic signed [OUT_W-1:0] re;
		logic signed [OUT_W-1:0] im;
		logic                    rend;
		logic                    fend;
	} stretched_bin_t;

	stretched_bin_t frames_due[$];

	logic [31:0]       atan_turns [CORDIC_STEPS];
	logic [STEP_W-1:0] step;
	logic [MAG_W-1:0]  last_mag [NBINS];
	logic [PH_W-1:0]   last_ph [NBINS];
	logic [PH_W-1:0]   synth_ph [NBINS];
	logic [15:0]       position;
	int                bin_no;
	logic              primed;

	initial begin
		longint acc;
		longint e;
		atan_turns[0] = 32'h2000_0000;
		for (int k = 1; k < CORDIC_STEPS; k++) begin
			acc = 0;
			for (int n = 0; n < 16; n++) begin
				e = k * (2 * n + 1);
				if (e <= 30)
					acc += ((n % 2) ? -1 : 1) * ((longint'(1) << (30 - e)) / (2 * n + 1));
			end
			atan_turns[k] = 32'((acc * 683565276 + (longint'(1) << 29)) >>> 30);
		end
	end

	function automatic void polar_of(input longint re, input longint im,
			output logic [MAG_W-1:0] mag, output logic [PH_W-1:0] ph);
		longint sq, r, t, x, y, xn, yn;
		logic [31:0] z;
		sq = re * re + im * im;
		r = 0;
		for (int b = 24; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= sq)
				r = t;
		end
		if (r * r + r < sq)
			r++;
		mag = MAG_W'(r);
		ph = '0;
		if (re != 0 || im != 0) begin
			x = re * 256;
			y = im * 256;
			z = 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				z = 32'h8000_0000;
			end
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				if (y >= 0) begin
					xn = x + (y >>> k);
					yn = y - (x >>> k);
					z += atan_turns[k];
				end else begin
					xn = x - (y >>> k);
					yn = y + (x >>> k);
					z -= atan_turns[k];
				end
				x = xn;
				y = yn;
			end
			z += 32'h8000;
			ph = z[31:16];
		end
	endfunction

	function automatic logic signed [OUT_W-1:0] saturate(input longint v);
		v = (v + 128) >>> 8;
		if (v > 11863283)
			v = 11863283;
		if (v < -11863284)
			v = -11863284;
		return OUT_W'(v);
	endfunction

	function automatic void cartesian_of(input logic [MAG_W-1:0] mag,
			input logic [PH_W-1:0] ph,
			output logic signed [OUT_W-1:0] re, output logic signed [OUT_W-1:0] im);
		longint x, y, xn, yn;
		logic [31:0] z, q;
		x = (longint'(mag) * longint'(INV_GAIN)) >>> 24;
		y = 0;
		z = {ph, 16'h0};
		q = z + 32'h4000_0000;
		if (q[31]) begin
			x = -x;
			z += 32'h8000_0000;
		end
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			if (!z[31]) begin
				xn = x - (y >>> k);
				yn = y + (x >>> k);
				z -= atan_turns[k];
			end else begin
				xn = x + (y >>> k);
				yn = y - (x >>> k);
				z += atan_turns[k];
			end
			x = xn;
			y = yn;
		end
		re = saturate(x);
		im = saturate(y);
	endfunction

	task automatic stretch_bin(input longint re, input longint im, input logic last);
		logic [MAG_W-1:0] nmag;
		logic [PH_W-1:0]  nph, half, dd;
		longint           pos, adv, m;
		int               slot, cnt;
		stretched_bin_t   r;
		slot = (bin_no > FRAME_LEN) ? FRAME_LEN : bin_no;
		polar_of(re, im, nmag, nph);
		if (primed) begin
			pos = position;
			cnt = 0;
			half = slot[0] ? 16'h8000 : 16'h0;
			dd = nph - last_ph[slot] - half;
			adv = (longint'($signed(dd)) * longint'(step) + 32768) >>> 16;
			while (pos < 65536 && cnt < MAX_RES) begin
				m = (longint'(last_mag[slot]) * (65536 - pos) + longint'(nmag) * pos
					+ 32768) >> 16;
				r.idx = IDX_W'(cnt);
				cartesian_of(MAG_W'(m), synth_ph[slot], r.re, r.im);
				r.rend = 1'b0;
				r.fend = last;
				frames_due.push_back(r);
				synth_ph[slot] = synth_ph[slot] + half + PH_W'(adv);
				pos += step;
				cnt++;
			end
			frames_due[$].rend = 1'b1;
			if (last)
				position = pos[15:0];
		end else begin
			synth_ph[slot] = nph;
		end
		last_mag[slot] = nmag;
		last_ph[slot] = nph;
		if (last) begin
			bin_no = 0;
			primed = 1'b1;
		end else if (bin_no < FRAME_LEN) begin
			bin_no++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stretched_bin_t e;
		if (!arst_n) begin
			step = STEP_RESET;
			position = '0;
			bin_no = 0;
			primed = 1'b0;
			frames_due.delete();
			errors = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				step = cfg_data;
			if (out_valid && !out_stall) begin
				checked++;
				if (frames_due.size() == 0) begin
					$error("result with no request pending: index %0d", frame_index);
					errors++;
				end else begin
					e = frames_due.pop_front();
					if (frame_index !== e.idx) begin
						$error("frame_index: expected %0d, got %0d", e.idx, frame_index);
						errors++;
					end
					if (out_real !== e.re) begin
						$error("out_real: expected %0d, got %0d", e.re, out_real);
						errors++;
					end
					if (out_imag !== e.im) begin
						$error("out_imag: expected %0d, got %0d", e.im, out_imag);
						errors++;
					end
					if (run_end !== e.rend) begin
						$error("run_end: expected %0b, got %0b", e.rend, run_end);
						errors++;
					end
					if (frame_end !== e.fend) begin
						$error("frame_end: expected %0b, got %0b", e.fend, frame_end);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				stretch_bin(bin_real, bin_imag, last_bin);
			pending = frames_due.size();
		end
	end

endmodule

### tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pvfs_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD = 3000;
	localparam int PRIME_BINS = 24;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [IN_W-1:0]   bin_real;
	logic signed [IN_W-1:0]   bin_imag;
	logic                     last_bin;
	logic                     out_valid;
	logic                     out_stall;
	logic [IDX_W-1:0]         frame_index;
	logic signed [OUT_W-1:0]  out_real;
	logic signed [OUT_W-1:0]  out_imag;
	logic                     run_end;
	logic                     frame_end;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [STEP_W-1:0]        cfg_data;
	int                       errors;
	int                       pending;
	int                       checked;
	int                       bins_sent;
	int                       burst_left;
	bit                       gaps_on;
	bit                       hold_req;
	int                       idle_cycles;

	phase_vocoder_frame_stretch_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.bin_real(bin_real), .bin_imag(bin_imag), .last_bin(last_bin),
		.out_valid(out_valid), .out_stall(out_stall),
		.frame_index(frame_index), .out_real(out_real), .out_imag(out_imag),
		.run_end(run_end), .frame_end(frame_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	pvfs_checker stretch_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.bin_real(bin_real), .bin_imag(bin_imag), .last_bin(last_bin),
		.out_valid(out_valid), .out_stall(out_stall),
		.frame_index(frame_index), .out_real(out_real), .out_imag(out_imag),
		.run_end(run_end), .frame_end(frame_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		bin_real = '0;
		bin_imag = '0;
		last_bin = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_req = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: random stall pattern, with one long hold-off on request
	initial begin
		int hold_left;
		int mode;
		hold_left = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if ($urandom_range(0, 149) == 0)
				mode = $urandom_range(0, 2);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (mode == 0) begin
				out_stall <= 1'b0;
			end else if (mode == 1) begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end else begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("phase_vocoder_frame_stretch_unit regression: fail");
			$finish;
		end
	end

	function automatic logic signed [IN_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return -24'sd8388608;
			1: return 24'sd8388607;
			2: return IN_W'($signed($urandom_range(0, 64)) - 32);
			default: return IN_W'($urandom);
		endcase
	endfunction

	task automatic send_bin(input logic signed [IN_W-1:0] re,
			input logic signed [IN_W-1:0] im, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(0, 9) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		bin_real <= re;
		bin_imag <= im;
		last_bin <= last;
		do @(posedge clk); while (in_stall);
		bins_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_step(input logic [STEP_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(input int nbins);
		for (int b = 0; b < nbins; b++)
			send_bin(pick_value(), pick_value(), b == nbins - 1);
	endtask

	initial begin
		logic signed [IN_W-1:0] edge_re [8];
		logic signed [IN_W-1:0] edge_im [8];
		int nbins;
		edge_re = '{0, 24'sd8388607, -24'sd8388608, -24'sd8388608, 0,
			24'sd8388607, -1, 1};
		edge_im = '{0, 24'sd8388607, -24'sd8388608, 0, -24'sd8388608,
			-24'sd8388608, 0, -1};
		bins_sent = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// priming frame, as long as any later frame
		for (int b = 0; b < 8; b++)
			send_bin(edge_re[b], edge_im[b], 1'b0);
		for (int b = 8; b < PRIME_BINS; b++)
			send_bin(pick_value(), pick_value(), b == PRIME_BINS - 1);
		drain();

		// corner bins at the reset step, then a step change mid-frame
		for (int b = 0; b < 4; b++)
			send_bin(edge_re[b], edge_im[b], 1'b0);
		drain();
		write_step(18'd1024);
		for (int b = 4; b < 8; b++)
			send_bin(edge_re[b], edge_im[b], b == 7);
		drain();
		write_step(18'd262143);
		send_frame(6);
		drain();
		write_step(18'd65536);
		send_frame(5);
		drain();
		write_step(18'd40000);

		gaps_on = 1'b0;
		send_frame(12);
		gaps_on = 1'b1;
		hold_req = 1'b1;
		send_frame(10);
		drain();

		while (bins_sent < 210) begin
			if ($urandom_range(0, 2) == 0) begin
				drain();
				if ($urandom_range(0, 9) == 0)
					write_step(18'd1024);
				else
					write_step(STEP_W'($urandom_range(16384, 262143)));
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			nbins = $urandom_range(1, PRIME_BINS);
			send_frame(nbins);
		end
		drain();

		$display("bins sent: %0d, interpolated results checked: %0d", bins_sent, checked);
		$display("steps from 1024 to 262143, corner bins, mid-frame step change, long output hold");
		if (errors == 0)
			$display("phase_vocoder_frame_stretch_unit regression: pass");
		else
			$display("phase_vocoder_frame_stretch_unit regression: fail");
		$finish;
	end

endmodule
